// File: design/bfm_pkg.sv
// ---------------------------------------------------------------------------
// bfm_pkg: shared definitions for the brainfuck machine core
// Sizes, command and event codes, and the command/status bundles between
// the controller and the datapath.
// ---------------------------------------------------------------------------
package bfm_pkg;

    localparam int TAPE_CELLS    = 32768;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int RUN_BUDGET    = 65536;

    localparam int TAPE_AW  = $clog2(TAPE_CELLS);
    localparam int PROG_AW  = $clog2(PROGRAM_DEPTH);
    localparam int LEN_W    = $clog2(PROGRAM_DEPTH + 1);
    localparam int SPENT_W  = $clog2(RUN_BUDGET + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_RESUME = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        SYM_INC   = 3'd0,
        SYM_DEC   = 3'd1,
        SYM_LEFT  = 3'd2,
        SYM_RIGHT = 3'd3,
        SYM_OPEN  = 3'd4,
        SYM_CLOSE = 3'd5,
        SYM_IN    = 3'd6,
        SYM_OUT   = 3'd7
    } t_sym;

    typedef enum logic [2:0] {
        EV_OK       = 3'd0,
        EV_FULL     = 3'd1,
        EV_OUTPUT   = 3'd2,
        EV_INPUT    = 3'd3,
        EV_HALT     = 3'd4,
        EV_NO_CLOSE = 3'd5,
        EV_NO_OPEN  = 3'd6
    } t_event;

    typedef struct packed {
        logic   clr;
        logic   sweep_wr;
        logic   append;
        logic   resume;
        logic   cell_inc;
        logic   cell_dec;
        logic   cell_load;
        logic   ptr_inc;
        logic   ptr_dec;
        logic   pc_inc;
        logic   spent_inc;
        logic   set_pending;
        logic   scan_sel;
        logic   scan_fwd_start;
        logic   scan_bwd_start;
        logic   scan_step;
        logic   scan_back;
        logic   scan_done;
        logic   emit;
        t_event ev;
        logic   emit_cell;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
        logic pending;
        logic budget_out;
        logic at_end;
        logic full;
        t_sym sym;
        logic cell_zero;
        logic pc_zero;
        logic idx_in;
        logic idx_zero;
        logic hit_fwd;
        logic hit_bwd;
        logic emit_ok;
    } t_dp_sts;

endpackage

// File: design/bfm_in_if.sv
// ---------------------------------------------------------------------------
// bfm_in_if: input channel of the brainfuck machine core
// One word carries an operation, a program symbol and an input byte.
// ---------------------------------------------------------------------------
interface bfm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [2:0] symbol;
    logic [7:0] input_byte;

    modport source (output valid, output op, output symbol, output input_byte, input ready);
    modport sink   (input valid, input op, input symbol, input input_byte, output ready);
endinterface

// File: design/bfm_out_if.sv
// ---------------------------------------------------------------------------
// bfm_out_if: result channel of the brainfuck machine core
// One word carries an event code and an output byte.
// ---------------------------------------------------------------------------
interface bfm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] out_byte;

    modport source (output valid, output event_res, output out_byte, input ready);
    modport sink   (input valid, input event_res, input out_byte, output ready);
endinterface

// File: design/bfm_datapath.sv
// ---------------------------------------------------------------------------
// bfm_datapath: storage and arithmetic of the brainfuck machine core
// Program store, tape, pointers, bracket scanner, run budget and the
// registered result word.
// ---------------------------------------------------------------------------
module bfm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfm_pkg::t_dp_cmd    i_cmd,
    input  logic [2:0]          i_symbol,
    input  logic [7:0]          i_input_byte,
    input  logic                i_out_ready,
    output bfm_pkg::t_dp_sts    o_sts,
    output logic                o_out_valid,
    output logic [2:0]          o_event_res,
    output logic [7:0]          o_out_byte
);

    localparam int TAPE_AW = bfm_pkg::TAPE_AW;
    localparam int PROG_AW = bfm_pkg::PROG_AW;
    localparam int LEN_W   = bfm_pkg::LEN_W;
    localparam int SPENT_W = bfm_pkg::SPENT_W;

    logic [7:0]         r_tape [bfm_pkg::TAPE_CELLS];
    logic [2:0]         r_prog [bfm_pkg::PROGRAM_DEPTH];
    logic [7:0]         r_tape_q;
    logic [2:0]         r_prog_q;

    logic [LEN_W-1:0]   r_len,   n_len;
    logic [LEN_W-1:0]   r_pc,    n_pc;
    logic [LEN_W-1:0]   r_idx,   n_idx;
    logic [LEN_W-1:0]   r_depth, n_depth;
    logic [TAPE_AW-1:0] r_ptr,   n_ptr;
    logic [TAPE_AW-1:0] r_sweep, n_sweep;
    logic [SPENT_W-1:0] r_spent, n_spent;
    logic [7:0]         r_cell,  n_cell;
    logic               r_pend,  n_pend;
    logic               r_out_valid;
    logic [2:0]         r_out_event;
    logic [7:0]         r_out_byte;

    logic               tape_we;
    logic [TAPE_AW-1:0] tape_wa;
    logic [7:0]         tape_wd;
    logic [LEN_W-1:0]   prog_ra;
    logic               in_write;
    bfm_pkg::t_sym      sym;
    bfm_pkg::t_sym      sym_up;
    bfm_pkg::t_sym      sym_down;

    assign sym      = bfm_pkg::t_sym'(r_prog_q);
    assign in_write = i_cmd.resume && r_pend;
    assign sym_up   = i_cmd.scan_back ? bfm_pkg::SYM_CLOSE : bfm_pkg::SYM_OPEN;
    assign sym_down = i_cmd.scan_back ? bfm_pkg::SYM_OPEN : bfm_pkg::SYM_CLOSE;

    always_comb begin
        n_len   = r_len;
        n_pc    = r_pc;
        n_idx   = r_idx;
        n_depth = r_depth;
        n_ptr   = r_ptr;
        n_sweep = r_sweep;
        n_spent = r_spent;
        n_cell  = r_cell;
        n_pend  = r_pend;

        if (i_cmd.clr) begin
            n_len   = '0;
            n_pc    = '0;
            n_ptr   = '0;
            n_sweep = '0;
            n_cell  = '0;
            n_pend  = 1'b0;
        end
        if (i_cmd.append) begin
            n_len = r_len + LEN_W'(1);
        end
        if (i_cmd.sweep_wr) begin
            n_sweep = (r_sweep == TAPE_AW'(bfm_pkg::TAPE_CELLS - 1)) ? '0
                                                                    : r_sweep + TAPE_AW'(1);
        end
        if (i_cmd.resume) begin
            n_spent = '0;
            n_pend  = 1'b0;
        end
        if (in_write) begin
            n_cell = i_input_byte;
        end
        if (i_cmd.set_pending) begin
            n_pend = 1'b1;
        end
        if (i_cmd.spent_inc) begin
            n_spent = r_spent + SPENT_W'(1);
        end
        if (i_cmd.cell_inc) begin
            n_cell = r_cell + 8'd1;
        end
        if (i_cmd.cell_dec) begin
            n_cell = r_cell - 8'd1;
        end
        if (i_cmd.cell_load) begin
            n_cell = r_tape_q;
        end
        if (i_cmd.ptr_inc) begin
            n_ptr = (r_ptr == TAPE_AW'(bfm_pkg::TAPE_CELLS - 1)) ? '0 : r_ptr + TAPE_AW'(1);
        end
        if (i_cmd.ptr_dec) begin
            n_ptr = (r_ptr == '0) ? TAPE_AW'(bfm_pkg::TAPE_CELLS - 1) : r_ptr - TAPE_AW'(1);
        end
        if (i_cmd.pc_inc) begin
            n_pc = r_pc + LEN_W'(1);
        end
        if (i_cmd.scan_fwd_start) begin
            n_idx   = r_pc + LEN_W'(1);
            n_depth = LEN_W'(1);
        end
        if (i_cmd.scan_bwd_start) begin
            n_idx   = r_pc - LEN_W'(1);
            n_depth = LEN_W'(1);
        end
        if (i_cmd.scan_step) begin
            n_idx = i_cmd.scan_back ? r_idx - LEN_W'(1) : r_idx + LEN_W'(1);
            if (sym == sym_up) begin
                n_depth = r_depth + LEN_W'(1);
            end else if (sym == sym_down) begin
                n_depth = r_depth - LEN_W'(1);
            end
        end
        if (i_cmd.scan_done) begin
            n_pc = r_idx + LEN_W'(1);
        end
    end

    // the sweep owns the write port; otherwise write through to the current cell
    assign tape_we = i_cmd.sweep_wr || in_write || i_cmd.cell_inc || i_cmd.cell_dec;
    assign tape_wa = i_cmd.sweep_wr ? r_sweep : r_ptr;
    assign tape_wd = i_cmd.sweep_wr ? 8'd0 : n_cell;
    assign prog_ra = i_cmd.scan_sel ? n_idx : n_pc;

    always_ff @(posedge i_clk) begin
        if (tape_we) begin
            r_tape[tape_wa] <= tape_wd;
        end
        r_tape_q <= r_tape[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_prog[r_len[PROG_AW-1:0]] <= i_symbol;
        end
        r_prog_q <= r_prog[prog_ra[PROG_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pc        <= '0;
            r_idx       <= '0;
            r_depth     <= '0;
            r_ptr       <= '0;
            r_sweep     <= '0;
            r_spent     <= '0;
            r_cell      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_pc    <= n_pc;
            r_idx   <= n_idx;
            r_depth <= n_depth;
            r_ptr   <= n_ptr;
            r_sweep <= n_sweep;
            r_spent <= n_spent;
            r_cell  <= n_cell;
            r_pend  <= n_pend;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_event <= i_cmd.ev;
            r_out_byte  <= i_cmd.emit_cell ? r_cell : 8'd0;
        end
    end

    always_comb begin
        o_sts.sweep_last = (r_sweep == TAPE_AW'(bfm_pkg::TAPE_CELLS - 1));
        o_sts.pending    = r_pend;
        o_sts.budget_out = (r_spent == SPENT_W'(bfm_pkg::RUN_BUDGET));
        o_sts.at_end     = (r_pc >= r_len);
        o_sts.full       = (r_len >= LEN_W'(bfm_pkg::PROGRAM_DEPTH));
        o_sts.sym        = sym;
        o_sts.cell_zero  = (r_cell == 8'd0);
        o_sts.pc_zero    = (r_pc == '0);
        o_sts.idx_in     = (r_idx < r_len);
        o_sts.idx_zero   = (r_idx == '0);
        o_sts.hit_fwd    = (sym == bfm_pkg::SYM_CLOSE) && (r_depth == LEN_W'(1));
        o_sts.hit_bwd    = (sym == bfm_pkg::SYM_OPEN) && (r_depth == LEN_W'(1));
        o_sts.emit_ok    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out_event;
    assign o_out_byte  = r_out_byte;

endmodule

// File: design/bfm_ctrl.sv
// ---------------------------------------------------------------------------
// bfm_ctrl: sequencer of the brainfuck machine core
// Takes input words, steps the interpreter one command per state visit and
// drives the datapath through a command bundle.
// ---------------------------------------------------------------------------
module bfm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_op,
    input  bfm_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output bfm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_SWEEP   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_CLR_ACK = 7'b0000100,
        S_EXEC    = 7'b0001000,
        S_LOAD    = 7'b0010000,
        S_SCAN_F  = 7'b0100000,
        S_SCAN_B  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_ack, n_clr_ack;

    always_comb begin
        n_state    = r_state;
        n_clr_ack  = r_clr_ack;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = r_clr_ack ? S_CLR_ACK : S_IDLE;
                end
            end
            S_CLR_ACK: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev   = bfm_pkg::EV_OK;
                    n_clr_ack  = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = i_sts.emit_ok;
                if (i_in_valid && i_sts.emit_ok) begin
                    case (bfm_pkg::t_op'(i_in_op))
                        bfm_pkg::OP_CLEAR: begin
                            o_cmd.clr = 1'b1;
                            n_clr_ack = 1'b1;
                            n_state   = S_SWEEP;
                        end
                        bfm_pkg::OP_APPEND: begin
                            o_cmd.emit = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.ev = bfm_pkg::EV_FULL;
                            end else begin
                                o_cmd.append = 1'b1;
                                o_cmd.ev     = bfm_pkg::EV_OK;
                            end
                        end
                        bfm_pkg::OP_RESUME: begin
                            o_cmd.resume = 1'b1;
                            n_state      = S_EXEC;
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.ev   = bfm_pkg::EV_OK;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                // hold everything until the result register can take a word
                if (i_sts.emit_ok) begin
                    if (i_sts.budget_out) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.ev   = bfm_pkg::EV_OK;
                        n_state    = S_IDLE;
                    end else if (i_sts.at_end) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.ev   = bfm_pkg::EV_HALT;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.spent_inc = 1'b1;
                        case (i_sts.sym)
                            bfm_pkg::SYM_INC: begin
                                o_cmd.cell_inc = 1'b1;
                                o_cmd.pc_inc   = 1'b1;
                            end
                            bfm_pkg::SYM_DEC: begin
                                o_cmd.cell_dec = 1'b1;
                                o_cmd.pc_inc   = 1'b1;
                            end
                            bfm_pkg::SYM_LEFT: begin
                                o_cmd.ptr_dec = 1'b1;
                                o_cmd.pc_inc  = 1'b1;
                                n_state       = S_LOAD;
                            end
                            bfm_pkg::SYM_RIGHT: begin
                                o_cmd.ptr_inc = 1'b1;
                                o_cmd.pc_inc  = 1'b1;
                                n_state       = S_LOAD;
                            end
                            bfm_pkg::SYM_OPEN: begin
                                if (i_sts.cell_zero) begin
                                    o_cmd.scan_fwd_start = 1'b1;
                                    o_cmd.scan_sel       = 1'b1;
                                    n_state              = S_SCAN_F;
                                end else begin
                                    o_cmd.pc_inc = 1'b1;
                                end
                            end
                            bfm_pkg::SYM_CLOSE: begin
                                if (i_sts.cell_zero) begin
                                    o_cmd.pc_inc = 1'b1;
                                end else if (i_sts.pc_zero) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.ev   = bfm_pkg::EV_NO_OPEN;
                                    n_state    = S_IDLE;
                                end else begin
                                    o_cmd.scan_bwd_start = 1'b1;
                                    o_cmd.scan_back      = 1'b1;
                                    o_cmd.scan_sel       = 1'b1;
                                    n_state              = S_SCAN_B;
                                end
                            end
                            bfm_pkg::SYM_IN: begin
                                o_cmd.pc_inc      = 1'b1;
                                o_cmd.set_pending = 1'b1;
                                o_cmd.emit        = 1'b1;
                                o_cmd.ev          = bfm_pkg::EV_INPUT;
                                n_state           = S_IDLE;
                            end
                            default: begin
                                o_cmd.pc_inc    = 1'b1;
                                o_cmd.emit      = 1'b1;
                                o_cmd.ev        = bfm_pkg::EV_OUTPUT;
                                o_cmd.emit_cell = 1'b1;
                                n_state         = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_LOAD: begin
                o_cmd.cell_load = 1'b1;
                n_state         = S_EXEC;
            end
            S_SCAN_F: begin
                // keep the read port on the scan index while stalled
                o_cmd.scan_sel = 1'b1;
                if (i_sts.emit_ok) begin
                    if (!i_sts.idx_in) begin
                        o_cmd.scan_sel = 1'b0;
                        o_cmd.emit     = 1'b1;
                        o_cmd.ev       = bfm_pkg::EV_NO_CLOSE;
                        n_state        = S_IDLE;
                    end else if (i_sts.hit_fwd) begin
                        o_cmd.scan_sel  = 1'b0;
                        o_cmd.scan_done = 1'b1;
                        n_state         = S_EXEC;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end
            end
            S_SCAN_B: begin
                o_cmd.scan_sel  = 1'b1;
                o_cmd.scan_back = 1'b1;
                if (i_sts.emit_ok) begin
                    if (i_sts.hit_bwd) begin
                        o_cmd.scan_sel  = 1'b0;
                        o_cmd.scan_done = 1'b1;
                        n_state         = S_EXEC;
                    end else if (i_sts.idx_zero) begin
                        o_cmd.scan_sel = 1'b0;
                        o_cmd.emit     = 1'b1;
                        o_cmd.ev       = bfm_pkg::EV_NO_OPEN;
                        n_state        = S_IDLE;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_clr_ack <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_ack <= n_clr_ack;
        end
    end

endmodule

// File: design/brainfuck_machine_core.sv
// ---------------------------------------------------------------------------
// brainfuck_machine_core: program loader and interpreter over a byte tape
// Input words (valid/ready) carry op, symbol and input_byte; every input word
// produces exactly one result word (event_res, out_byte) on the output port.
//   Append and unused ops: the result is registered on acceptance.
//   Clear: a sweep zeroes all TAPE_CELLS (32768) cells of the tape, one cell
//     per cycle through the tape write port, then the result follows.
//   Resume: +, -, [ and ] not taken, '.' and ',' run in the execute state;
//     < and > also pass a load state (new cell read from the tape memory).
//     A taken bracket scans one program symbol per cycle while the result
//     register can take a word. A resume runs at most RUN_BUDGET commands,
//     and each scan covers at most PROGRAM_DEPTH symbols.
// Reset starts the same tape sweep; no input word is accepted until it ends.
// A new word is accepted in the idle state whenever the result register is
// free or being read; while the receiver stalls the sequencer holds where
// it would emit, and the pending result stays stable.
// ---------------------------------------------------------------------------
module brainfuck_machine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfm_in_if.sink     i_in,
    bfm_out_if.source  o_out
);

    bfm_pkg::t_dp_cmd cmd;
    bfm_pkg::t_dp_sts sts;
    logic             in_ready;

    bfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    bfm_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_symbol     (i_in.symbol),
        .i_input_byte (i_in.input_byte),
        .i_out_ready  (o_out.ready),
        .o_sts        (sts),
        .o_out_valid  (o_out.valid),
        .o_event_res  (o_out.event_res),
        .o_out_byte   (o_out.out_byte)
    );

    assign i_in.ready = in_ready;

endmodule
